### src/sldf_pkg.sv
// Package for the length-prefixed deframer: phase codes, register indexes,
// reset values and the structs passed between the core and the top level.
// No dependencies.
`default_nettype none

package sldf_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH_LIMIT = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SYNC_FIRST_RST   = 8'd148;
  localparam logic [7:0]  SYNC_SECOND_RST  = 8'd195;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd508;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EMPTY   = 1'b1;

  // Receive phase of the deframer.
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  // Configuration seen by the core.
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] length_limit;
  } cfg_t;

  // One result beat, with its valid flag.
  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [15:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

### src/sldf_core.sv
// Header parser and payload counter of the deframer. Holds the phase state
// machine and the length registers. Depends on sldf_pkg.
`default_nettype none

module sldf_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat_en,
  input  wire logic [7:0]    rx_byte,
  input  sldf_pkg::cfg_t     cfg,
  output sldf_pkg::res_t     res
);
  import sldf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] hdr_len;

  assign hdr_len = {length_high_r, rx_byte};

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      length_high_r <= '0;
      frame_len_r   <= '0;
      bytes_left_r  <= '0;
    end else if (beat_en) begin
      phase_r       <= phase_nxt;
      length_high_r <= length_high_nxt;
      frame_len_r   <= frame_len_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

  // Next phase and the result for the current byte.
  always_comb begin
    phase_nxt       = phase_r;
    length_high_nxt = length_high_r;
    frame_len_nxt   = frame_len_r;
    bytes_left_nxt  = bytes_left_r;
    res             = '0;
    case (phase_r)
      PH_SYNC2: begin
        // A wrong second sync byte drops both header bytes.
        phase_nxt = (rx_byte == cfg.sync_second) ? PH_LENHI : PH_HUNT;
      end
      PH_LENHI: begin
        length_high_nxt = rx_byte;
        phase_nxt       = PH_LENLO;
      end
      PH_LENLO: begin
        frame_len_nxt = hdr_len;
        if (hdr_len == '0) begin
          // An empty frame reports at once, whatever the limit.
          phase_nxt          = PH_HUNT;
          bytes_left_nxt     = '0;
          res.vld            = beat_en;
          res.kind           = KIND_EMPTY;
          res.frame_last     = 1'b1;
        end else if (hdr_len >= cfg.length_limit) begin
          phase_nxt      = PH_HUNT;
          bytes_left_nxt = '0;
        end else begin
          bytes_left_nxt = hdr_len;
          phase_nxt      = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_left_nxt   = bytes_left_r - 16'd1;
        res.vld          = beat_en;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.frame_length = frame_len_r;
        if (bytes_left_r == 16'd1) begin
          phase_nxt      = PH_HUNT;
          res.frame_last = 1'b1;
        end
      end
      default: begin
        // Hunting, and any code without meaning.
        phase_nxt = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/sync_length_prefixed_deframer.sv
// Result beats are registered in the output or, on a stall, the skid register.
// Throughput: one input beat per cycle; the output register plus one skid
// register keep the input open while a finished result waits to be taken.
// The input stalls only when both the output and the skid register are full.
// Reset (rst_n, synchronous, active low) restores the register reset values
// and starts hunting for the first sync byte with no result pending.
`default_nettype none

module sync_length_prefixed_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kind,
  output logic [7:0]                         out_payload_byte,
  output logic                               out_frame_last,
  output logic [15:0]                        out_frame_length,
  input  wire logic                          cfg_we,
  input  wire logic [sldf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sldf_pkg::CfgDataW-1:0] cfg_wdata
);
  import sldf_pkg::*;

  cfg_t cfg_r;
  res_t core_res;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic in_acc;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first   <= SYNC_FIRST_RST;
      cfg_r.sync_second  <= SYNC_SECOND_RST;
      cfg_r.length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:   cfg_r.sync_first   <= cfg_wdata[7:0];
        CFG_SYNC_SECOND:  cfg_r.sync_second  <= cfg_wdata[7:0];
        CFG_LENGTH_LIMIT: cfg_r.length_limit <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_r.vld;
  assign in_acc   = in_valid && in_ready;

  sldf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (in_acc),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  // Output register with one skid register behind it.
  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.vld || out_ready) begin
      if (skid_r.vld) begin
        out_nxt      = skid_r;
        skid_nxt.vld = 1'b0;
      end else begin
        out_nxt = core_res;
      end
    end else if (core_res.vld) begin
      skid_nxt = core_res;
    end
  end

  // Result registers; only the valid flags are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld  <= 1'b0;
      skid_r.vld <= 1'b0;
    end else begin
      out_r  <= out_nxt;
      skid_r <= skid_nxt;
    end
  end

  assign out_valid        = out_r.vld;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_frame_last   = out_r.frame_last;
  assign out_frame_length = out_r.frame_length;

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.vld |-> out_r.vld)
    else $error("skid register holds a beat while the output is empty");

  // A held skid beat is not lost while the output stalls.
  a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.vld && !out_ready |=> skid_r.vld && out_r.vld)
    else $error("skid beat dropped during an output stall");

  // An empty-frame result carries the last mark and no data.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.vld && (out_r.kind == KIND_EMPTY) |->
      out_r.frame_last && (out_r.payload_byte == 8'd0) && (out_r.frame_length == 16'd0))
    else $error("malformed empty-frame result");

endmodule

`default_nettype wire
